[rtl/ggw_pkg.sv]
// Shared types, codes and constants for the greedy grid walk block.
// No dependencies; imported by ggw_move_sel and greedy_grid_walk.
package ggw_pkg;

    localparam int GRID_DIM = 16;   // rows and columns of the stored map
    localparam int COORD_W  = 4;
    localparam int DIM_W    = 5;
    localparam int LIMIT_W  = 12;
    localparam int STEP_W   = 13;
    localparam int CFG_IDX_W = 2;

    typedef logic [GRID_DIM-1:0] row_t;
    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [DIM_W-1:0]    dim_t;
    typedef logic [LIMIT_W-1:0]  limit_t;
    typedef logic [STEP_W-1:0]   step_t;

    localparam dim_t   RESET_WIDTH  = 5'd10;
    localparam dim_t   RESET_HEIGHT = 5'd9;
    localparam limit_t RESET_LIMIT  = 12'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

    localparam logic OP_WALL   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_GOAL    = 2'd0,
        ST_LIMIT   = 2'd1,
        ST_OUTSIDE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        DIR_STAY,
        DIR_EAST,
        DIR_WEST,
        DIR_SOUTH,
        DIR_NORTH
    } dir_t;

    typedef struct packed {
        dir_t dir;
        logic dead;
    } move_t;

    // usable extent: configured size limited to the stored map
    function automatic dim_t dim_clamp(dim_t v);
        return (v > DIM_W'(GRID_DIM)) ? DIM_W'(GRID_DIM) : v;
    endfunction

endpackage

[rtl/greedy_grid_walk.sv]
// Top level of the greedy grid walk block: wall and work map memories,
// search sequencer, config registers. Depends on ggw_pkg and ggw_move_sel.
//
// A wall row beat (operation 0) gives no result. A search beat copies the
// 16-row wall map into a work map, one row per cycle, then walks: each step
// passes through a read state, which reads the rows above and below the
// current cell from the work map, and an execute state, which picks the move
// and writes the current row back with its visited bit set. A start or goal
// outside the map skips the copy and the walk and goes straight to the done
// state. The input is stalled for the whole search; a finished result waits
// in the output register while the next beat is accepted.
module greedy_grid_walk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ggw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ggw_pkg::LIMIT_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic [3:0]                     row_index,
    input  logic [15:0]                    row_walls,
    input  logic [3:0]                     start_x,
    input  logic [3:0]                     start_y,
    input  logic [3:0]                     goal_x,
    input  logic [3:0]                     goal_y,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [12:0]                    steps_taken,
    output logic [3:0]                     final_x,
    output logic [3:0]                     final_y,
    output logic                           hit_dead_end
);
    import ggw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY,
        S_COPY_END,
        S_RD,
        S_EX,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    dim_t    width_reg, width_next;
    dim_t    height_reg, height_next;
    limit_t  limit_reg, limit_next;
    coord_t  cx_reg, cx_next;
    coord_t  cy_reg, cy_next;
    coord_t  gx_reg, gx_next;
    coord_t  gy_reg, gy_next;
    step_t   steps_reg, steps_next;
    logic    dead_reg, dead_next;
    logic    oob_reg, oob_next;
    row_t    cur_row_reg, cur_row_next;
    coord_t  copy_cnt_reg, copy_cnt_next;
    logic    copy_wr_reg, copy_wr_next;
    coord_t  copy_waddr_reg, copy_waddr_next;
    row_t    wall_vld_reg, wall_vld_next;

    logic    out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    step_t   steps_out_reg, steps_out_next;
    coord_t  fx_reg, fx_next;
    coord_t  fy_reg, fy_next;
    logic    dead_out_reg, dead_out_next;

    // memories
    row_t    wall_mem [GRID_DIM];
    row_t    work_mem [GRID_DIM];
    row_t    wall_rd_reg;
    logic    wall_rd_vld_reg;
    row_t    up_rd_reg;
    row_t    dn_rd_reg;

    logic    in_accept;
    logic    wall_we;
    logic    work_we;
    coord_t  work_waddr;
    row_t    work_wdata;
    row_t    wall_row;
    row_t    row_marked;
    dim_t    w_eff;
    dim_t    h_eff;
    logic    at_goal;
    logic    outside;
    logic    out_free;
    move_t   move;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign wall_we   = in_accept && (operation == OP_WALL);

    assign w_eff   = dim_clamp(width_reg);
    assign h_eff   = dim_clamp(height_reg);
    assign at_goal = (cx_reg == gx_reg) && (cy_reg == gy_reg);
    assign outside = ({1'b0, start_x} >= w_eff) || ({1'b0, start_y} >= h_eff)
                  || ({1'b0, goal_x} >= w_eff) || ({1'b0, goal_y} >= h_eff);
    assign out_free = !out_valid_reg || !out_stall;

    // rows never written read as open
    assign wall_row   = wall_rd_vld_reg ? wall_rd_reg : '0;
    assign row_marked = cur_row_reg | (row_t'(1) << cx_reg);

    ggw_move_sel u_move_sel (
        .cur_x   (cx_reg),
        .cur_y   (cy_reg),
        .goal_x  (gx_reg),
        .goal_y  (gy_reg),
        .w       (w_eff),
        .h       (h_eff),
        .row_up  (up_rd_reg),
        .row_cur (row_marked),
        .row_dn  (dn_rd_reg),
        .move    (move)
    );

    // work map write port: copy sweep or step write-back
    always_comb
    begin
        work_we    = 1'b0;
        work_waddr = copy_waddr_reg;
        work_wdata = wall_row;
        if (copy_wr_reg)
            work_we = 1'b1;
        else if (state_reg == S_EX)
        begin
            work_we    = 1'b1;
            work_waddr = cy_reg;
            work_wdata = row_marked;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wall_we)
            wall_mem[row_index] <= row_walls;
        wall_rd_reg <= wall_mem[copy_cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
            work_mem[work_waddr] <= work_wdata;
        up_rd_reg <= work_mem[cy_reg - COORD_W'(1)];
        dn_rd_reg <= work_mem[cy_reg + COORD_W'(1)];
    end

    always_comb
    begin
        state_next      = state_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        limit_next      = limit_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        steps_next      = steps_reg;
        dead_next       = dead_reg;
        oob_next        = oob_reg;
        cur_row_next    = cur_row_reg;
        copy_cnt_next   = copy_cnt_reg;
        copy_wr_next    = 1'b0;
        copy_waddr_next = copy_waddr_reg;
        wall_vld_next   = wall_vld_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        steps_out_next  = steps_out_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        dead_out_next   = dead_out_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_next  = cfg_data[DIM_W-1:0];
                CFG_HEIGHT: height_next = cfg_data[DIM_W-1:0];
                CFG_LIMIT:  limit_next  = cfg_data;
                default:    ;
            endcase
        end

        if (wall_we)
            wall_vld_next[row_index] = 1'b1;

        // pick up the start row as it passes through the copy
        if (copy_wr_reg && copy_waddr_reg == cy_reg)
            cur_row_next = wall_row;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && operation == OP_SEARCH)
                begin
                    cx_next       = start_x;
                    cy_next       = start_y;
                    gx_next       = goal_x;
                    gy_next       = goal_y;
                    steps_next    = '0;
                    dead_next     = 1'b0;
                    oob_next      = outside;
                    copy_cnt_next = '0;
                    state_next    = outside ? S_DONE : S_COPY;
                end
            end
            S_COPY:
            begin
                copy_wr_next    = 1'b1;
                copy_waddr_next = copy_cnt_reg;
                copy_cnt_next   = copy_cnt_reg + COORD_W'(1);
                if (copy_cnt_reg == COORD_W'(GRID_DIM - 1))
                    state_next = S_COPY_END;
            end
            S_COPY_END:
            begin
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = at_goal ? S_DONE : S_EX;
            end
            S_EX:
            begin
                steps_next = steps_reg + STEP_W'(1);
                dead_next  = dead_reg | move.dead;
                case (move.dir)
                    DIR_EAST:
                    begin
                        cx_next      = cx_reg + COORD_W'(1);
                        cur_row_next = row_marked;
                    end
                    DIR_WEST:
                    begin
                        cx_next      = cx_reg - COORD_W'(1);
                        cur_row_next = row_marked;
                    end
                    DIR_SOUTH:
                    begin
                        cy_next      = cy_reg + COORD_W'(1);
                        cur_row_next = dn_rd_reg;
                    end
                    DIR_NORTH:
                    begin
                        cy_next      = cy_reg - COORD_W'(1);
                        cur_row_next = up_rd_reg;
                    end
                    default:
                    begin
                        cur_row_next = row_marked;
                    end
                endcase
                if (steps_next > {1'b0, limit_reg})
                    state_next = S_DONE;
                else
                    state_next = S_RD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (oob_reg)
                        status_next = ST_OUTSIDE;
                    else if (at_goal)
                        status_next = ST_GOAL;
                    else
                        status_next = ST_LIMIT;
                    steps_out_next = steps_reg;
                    fx_next        = cx_reg;
                    fy_next        = cy_reg;
                    dead_out_next  = dead_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            width_reg      <= RESET_WIDTH;
            height_reg     <= RESET_HEIGHT;
            limit_reg      <= RESET_LIMIT;
            copy_cnt_reg   <= '0;
            copy_wr_reg    <= 1'b0;
            wall_vld_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            limit_reg      <= limit_next;
            copy_cnt_reg   <= copy_cnt_next;
            copy_wr_reg    <= copy_wr_next;
            wall_vld_reg   <= wall_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cx_reg          <= cx_next;
        cy_reg          <= cy_next;
        gx_reg          <= gx_next;
        gy_reg          <= gy_next;
        steps_reg       <= steps_next;
        dead_reg        <= dead_next;
        oob_reg         <= oob_next;
        cur_row_reg     <= cur_row_next;
        copy_waddr_reg  <= copy_waddr_next;
        wall_rd_vld_reg <= wall_vld_reg[copy_cnt_reg];
        status_reg      <= status_next;
        steps_out_reg   <= steps_out_next;
        fx_reg          <= fx_next;
        fy_reg          <= fy_next;
        dead_out_reg    <= dead_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign steps_taken  = steps_out_reg;
    assign final_x      = fx_reg;
    assign final_y      = fy_reg;
    assign hit_dead_end = dead_out_reg;

endmodule

[rtl/ggw_move_sel.sv]
// Neighbor selection for one walk step: bounds, wall and visited checks
// in greedy priority order. Depends on ggw_pkg.
module ggw_move_sel (
    input  ggw_pkg::coord_t cur_x,
    input  ggw_pkg::coord_t cur_y,
    input  ggw_pkg::coord_t goal_x,
    input  ggw_pkg::coord_t goal_y,
    input  ggw_pkg::dim_t   w,
    input  ggw_pkg::dim_t   h,
    input  ggw_pkg::row_t   row_up,
    input  ggw_pkg::row_t   row_cur,
    input  ggw_pkg::row_t   row_dn,
    output ggw_pkg::move_t  move
);
    import ggw_pkg::*;

    logic [DIM_W-1:0] east_x;
    logic [DIM_W-1:0] south_y;
    coord_t           west_x;
    logic             ok_e;
    logic             ok_w;
    logic             ok_s;
    logic             ok_n;

    // row_* hold wall or visited bits; a set bit blocks the cell
    always_comb
    begin
        east_x  = {1'b0, cur_x} + DIM_W'(1);
        south_y = {1'b0, cur_y} + DIM_W'(1);
        west_x  = cur_x - COORD_W'(1);
        ok_e = (east_x < w) && !row_cur[east_x[COORD_W-1:0]];
        ok_w = (cur_x != '0) && !row_cur[west_x];
        ok_s = (south_y < h) && !row_dn[cur_x];
        ok_n = (cur_y != '0) && !row_up[cur_x];
    end

    always_comb
    begin
        move.dead = 1'b0;
        if (cur_x < goal_x && ok_e)
            move.dir = DIR_EAST;
        else if (cur_y < goal_y && ok_s)
            move.dir = DIR_SOUTH;
        else if (cur_x > goal_x && ok_w)
            move.dir = DIR_WEST;
        else if (cur_y > goal_y && ok_n)
            move.dir = DIR_NORTH;
        else if (ok_e)
            move.dir = DIR_EAST;
        else if (ok_w)
            move.dir = DIR_WEST;
        else if (ok_s)
            move.dir = DIR_SOUTH;
        else if (ok_n)
            move.dir = DIR_NORTH;
        else
        begin
            move.dir  = DIR_STAY;
            move.dead = 1'b1;
        end
    end

endmodule

[tb/greedy_grid_walk_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for greedy_grid_walk: directed table, then random phases
// under several map sizes and step limits, checked against an in-bench walk predictor.
// Depends on ggw_pkg and the greedy_grid_walk RTL.
module greedy_grid_walk_tb;
    import ggw_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int TAIL_CYCLES = 8;
    localparam int HOLD_CYCLES = 2000;
    localparam int HOLD_AFTER  = 30;
    localparam int PHASES      = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped index, must be ignored

    typedef struct packed {
        logic   op;
        coord_t row;
        row_t   walls;
        coord_t sx;
        coord_t sy;
        coord_t gx;
        coord_t gy;
    } walk_item_t;

    typedef struct packed {
        status_t status;
        step_t   steps;
        coord_t  fx;
        coord_t  fy;
        logic    dead;
    } walk_res_t;

    typedef struct packed {
        bit         is_cfg;
        dim_t       w;
        dim_t       h;
        limit_t     lim;
        walk_item_t it;
        bit         fixed;
        walk_res_t  want;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LIMIT_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 operation = 1'b0;
    logic [3:0]           row_index = '0;
    logic [15:0]          row_walls = '0;
    logic [3:0]           start_x = '0;
    logic [3:0]           start_y = '0;
    logic [3:0]           goal_x = '0;
    logic [3:0]           goal_y = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic [12:0]          steps_taken;
    logic [3:0]           final_x;
    logic [3:0]           final_y;
    logic                 hit_dead_end;

    greedy_grid_walk dut (.*);

    // predictor state
    row_t   wall_rows [GRID_DIM];
    row_t   seen_rows [GRID_DIM];
    dim_t   cur_w   = RESET_WIDTH;
    dim_t   cur_h   = RESET_HEIGHT;
    limit_t cur_lim = RESET_LIMIT;

    walk_res_t pending_walks [$];
    plan_row_t walk_plan [$];
    int        mismatch_count = 0;
    int        results_seen = 0;
    bit        steady_run = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        foreach (wall_rows[i]) wall_rows[i] = '0;
    end

    function automatic bit open_cell(int x, int y, int w, int h);
        if (x < 0 || y < 0 || x >= w || y >= h)
            return 1'b0;
        return !wall_rows[y][x] && !seen_rows[y][x];
    endfunction

    // returns 1 when the beat produces a result
    function automatic bit predict_walk(input walk_item_t it, output walk_res_t r);
        int  w;
        int  h;
        int  cx;
        int  cy;
        int  gx;
        int  gy;
        int  n;
        bit  dead;
        r = '0;
        if (it.op == OP_WALL)
        begin
            wall_rows[it.row] = it.walls;
            return 1'b0;
        end
        w  = (cur_w > GRID_DIM) ? GRID_DIM : int'(cur_w);
        h  = (cur_h > GRID_DIM) ? GRID_DIM : int'(cur_h);
        cx = it.sx;
        cy = it.sy;
        gx = it.gx;
        gy = it.gy;
        r.fx = it.sx;
        r.fy = it.sy;
        if (cx >= w || cy >= h || gx >= w || gy >= h)
        begin
            r.status = ST_OUTSIDE;
            return 1'b1;
        end
        foreach (seen_rows[i]) seen_rows[i] = '0;
        n = 0;
        dead = 1'b0;
        while (cx != gx || cy != gy)
        begin
            n++;
            seen_rows[cy][cx] = 1'b1;
            // toward the goal first, then any direction
            if (cx < gx && open_cell(cx + 1, cy, w, h)) cx++;
            else if (cy < gy && open_cell(cx, cy + 1, w, h)) cy++;
            else if (cx > gx && open_cell(cx - 1, cy, w, h)) cx--;
            else if (cy > gy && open_cell(cx, cy - 1, w, h)) cy--;
            else if (open_cell(cx + 1, cy, w, h)) cx++;
            else if (open_cell(cx - 1, cy, w, h)) cx--;
            else if (open_cell(cx, cy + 1, w, h)) cy++;
            else if (open_cell(cx, cy - 1, w, h)) cy--;
            else dead = 1'b1;
            if (n > cur_lim)
                break;
        end
        r.status = (cx == gx && cy == gy) ? ST_GOAL : ST_LIMIT;
        r.steps  = step_t'(n);
        r.fx     = coord_t'(cx);
        r.fy     = coord_t'(cy);
        r.dead   = dead;
        return 1'b1;
    endfunction

    function automatic plan_row_t cfg_row(dim_t w, dim_t h, limit_t lim);
        plan_row_t t;
        t = '0;
        t.is_cfg = 1'b1;
        t.w = w;
        t.h = h;
        t.lim = lim;
        return t;
    endfunction

    function automatic plan_row_t wall_row(coord_t r, row_t bits);
        plan_row_t t;
        t = '0;
        t.it.op = OP_WALL;
        t.it.row = r;
        t.it.walls = bits;
        return t;
    endfunction

    function automatic plan_row_t search_row(coord_t sx, coord_t sy, coord_t gx, coord_t gy);
        plan_row_t t;
        t = '0;
        t.it.op = OP_SEARCH;
        t.it.sx = sx;
        t.it.sy = sy;
        t.it.gx = gx;
        t.it.gy = gy;
        return t;
    endfunction

    function automatic plan_row_t fixed_row(coord_t sx, coord_t sy, coord_t gx, coord_t gy,
                                            status_t st, step_t n, coord_t fx, coord_t fy,
                                            logic dead);
        plan_row_t t;
        t = search_row(sx, sy, gx, gy);
        t.fixed = 1'b1;
        t.want.status = st;
        t.want.steps = n;
        t.want.fx = fx;
        t.want.fy = fy;
        t.want.dead = dead;
        return t;
    endfunction

    function automatic void cmp_field(input string name, input int unsigned want,
                                      input logic [12:0] got);
        if (got !== 13'(want))
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic check_result();
        walk_res_t exp;
        if (pending_walks.size() == 0)
        begin
            $error("result beat with no search outstanding");
            mismatch_count++;
            return;
        end
        exp = pending_walks.pop_front();
        results_seen++;
        cmp_field("status", exp.status, 13'(status));
        cmp_field("steps_taken", exp.steps, steps_taken);
        cmp_field("final_x", exp.fx, 13'(final_x));
        cmp_field("final_y", exp.fy, 13'(final_y));
        cmp_field("hit_dead_end", exp.dead, 13'(hit_dead_end));
    endtask

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_item(input walk_item_t it, input bit fixed, input walk_res_t want);
        walk_res_t pred;
        while (!steady_run && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= it.op;
        row_index <= it.row;
        row_walls <= it.walls;
        start_x   <= it.sx;
        start_y   <= it.sy;
        goal_x    <= it.gx;
        goal_y    <= it.gy;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_walk(it, pred))
            pending_walks.push_back(fixed ? want : pred);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_walks.size() != 0)
            @(posedge clk);
        // a trailing wall row write may still be in flight
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // upper data bits of the size registers are junk and must be dropped
    task automatic load_map_cfg(input dim_t w, input dim_t h, input limit_t lim);
        cfg_write <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= {7'($urandom), w};
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= {7'($urandom), h};
        @(posedge clk);
        cfg_index <= CFG_LIMIT;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= LIMIT_W'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_w   = w;
        cur_h   = h;
        cur_lim = lim;
    endtask

    // result side: random stalls plus one long hold-off to back the block up
    initial
    begin : result_side
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_result();
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!held && results_seen == HOLD_AFTER)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !steady_run && ($urandom_range(99) < 30);
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[greedy_grid_walk] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        walk_item_t it;
        dim_t       pw;
        dim_t       ph;
        limit_t     pl;
        int         eff_w;
        int         eff_h;
        int         n_items;

        // reset map 10 x 9, limit 1000
        walk_plan.push_back(fixed_row(0, 0, 0, 0, ST_GOAL, 0, 0, 0, 1'b0));
        walk_plan.push_back(search_row(9, 8, 0, 0));
        walk_plan.push_back(search_row(0, 0, 9, 8));
        walk_plan.push_back(fixed_row(10, 0, 0, 0, ST_OUTSIDE, 0, 10, 0, 1'b0));
        walk_plan.push_back(fixed_row(0, 0, 0, 9, ST_OUTSIDE, 0, 0, 0, 1'b0));
        walk_plan.push_back(fixed_row(15, 15, 15, 15, ST_OUTSIDE, 0, 15, 15, 1'b0));
        walk_plan.push_back(wall_row(15, 16'hFFFF));
        walk_plan.push_back(wall_row(0, 16'h0000));
        walk_plan.push_back(wall_row(1, 16'h0004));
        walk_plan.push_back(search_row(0, 1, 5, 1));
        // wall in cell (5,5) on all four sides
        walk_plan.push_back(wall_row(4, 16'h0020));
        walk_plan.push_back(wall_row(6, 16'h0020));
        walk_plan.push_back(wall_row(5, 16'h0050));
        walk_plan.push_back(search_row(0, 0, 5, 5));
        // zero limit: one step only, goal on that step still counts
        walk_plan.push_back(cfg_row(16, 16, 0));
        walk_plan.push_back(fixed_row(0, 0, 3, 0, ST_LIMIT, 1, 1, 0, 1'b0));
        walk_plan.push_back(fixed_row(0, 0, 1, 0, ST_GOAL, 1, 1, 0, 1'b0));
        walk_plan.push_back(search_row(15, 15, 0, 0));
        walk_plan.push_back(cfg_row(0, 16, 5));
        walk_plan.push_back(fixed_row(0, 0, 0, 0, ST_OUTSIDE, 0, 0, 0, 1'b0));
        // oversized map clamps to 16 x 16; longest limit
        walk_plan.push_back(cfg_row(31, 17, 4095));
        walk_plan.push_back(search_row(15, 15, 0, 0));
        walk_plan.push_back(search_row(0, 0, 5, 5));
        walk_plan.push_back(search_row(5, 5, 0, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (walk_plan[i])
        begin
            if (walk_plan[i].is_cfg)
            begin
                wait_idle();
                load_map_cfg(walk_plan[i].w, walk_plan[i].h, walk_plan[i].lim);
            end
            else
            begin
                send_item(walk_plan[i].it, walk_plan[i].fixed, walk_plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0:
                begin
                    pw = 16;
                    ph = 16;
                    pl = limit_t'($urandom_range(40));
                end
                1:
                begin
                    pw = 1;
                    ph = 1;
                    pl = 0;
                end
                2:
                begin
                    pw = 16;
                    ph = 16;
                    pl = 4095;
                end
                default:
                begin
                    pw = ($urandom_range(9) == 0) ? dim_t'($urandom_range(31))
                                                  : dim_t'($urandom_range(16, 1));
                    ph = ($urandom_range(9) == 0) ? dim_t'($urandom_range(31))
                                                  : dim_t'($urandom_range(16, 1));
                    pl = ($urandom_range(99) < 15) ? limit_t'($urandom_range(200, 41))
                                                   : limit_t'($urandom_range(40));
                end
            endcase
            load_map_cfg(pw, ph, pl);
            steady_run = (p == 3);
            eff_w = (pw > GRID_DIM) ? GRID_DIM : int'(pw);
            eff_h = (ph > GRID_DIM) ? GRID_DIM : int'(ph);
            // the longest limit phase is kept short, as a dead end walks on to the step limit
            n_items = (p == 2) ? 8 : 50;
            for (int k = 0; k < n_items; k++)
            begin
                it.op  = ($urandom_range(99) < 35) ? OP_WALL : OP_SEARCH;
                it.row = (eff_h > 0 && $urandom_range(3) != 0) ?
                         coord_t'($urandom_range(eff_h - 1)) : coord_t'($urandom);
                case ($urandom_range(9))
                    0:       it.walls = '1;
                    1:       it.walls = '0;
                    2, 3, 4: it.walls = row_t'($urandom & $urandom);
                    default: it.walls = row_t'($urandom & $urandom & $urandom);
                endcase
                if (eff_w > 0 && eff_h > 0 && $urandom_range(99) < 85)
                begin
                    it.sx = coord_t'($urandom_range(eff_w - 1));
                    it.sy = coord_t'($urandom_range(eff_h - 1));
                    it.gx = coord_t'($urandom_range(eff_w - 1));
                    it.gy = coord_t'($urandom_range(eff_h - 1));
                end
                else
                begin
                    it.sx = coord_t'($urandom);
                    it.sy = coord_t'($urandom);
                    it.gx = coord_t'($urandom);
                    it.gy = coord_t'($urandom);
                end
                send_item(it, 1'b0, '0);
            end
            steady_run = 1'b0;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("[greedy_grid_walk] OK");
        else
            $display("[greedy_grid_walk] ERROR");
        $finish;
    end

endmodule
